@@ rtl/pdag_pkg.sv @@
// Shared types and constants for the peak-driven automatic gain block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pdag_pkg;

  // Payload widths
  localparam int PEAK_W     = 18;
  localparam int TIME_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAIN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_GAIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIMB_TARGET = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUCK_RATE    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIMB_RATE   = 4'd7;

  // Register reset values
  localparam logic signed [GAIN_W-1:0] RST_MIN_GAIN     = -16'sd6144;
  localparam logic signed [GAIN_W-1:0] RST_MAX_GAIN     = 16'sd6144;
  localparam logic signed [GAIN_W-1:0] RST_START_GAIN   = 16'sd0;
  localparam logic [PEAK_W-1:0]        RST_SILENCE      = 18'd66;
  localparam logic [PEAK_W-1:0]        RST_CEILING      = 18'd62259;
  localparam logic [PEAK_W-1:0]        RST_CLIMB_TARGET = 18'd45875;
  localparam logic [TIME_W-1:0]        RST_DUCK_RATE    = 16'd15360;
  localparam logic [TIME_W-1:0]        RST_CLIMB_RATE   = 16'd768;

  // Default tuning
  localparam int DEF_PEAK_HALF_LIFE    = 65536;
  localparam int DEF_DUCK_MARGIN       = 256;
  localparam int DEF_MEMORY_RESET_TIME = 131072;
  localparam int DEF_CLIMB_DELAY       = 32768;

  // Fixed arithmetic constants
  localparam int TACC_W      = 24;      // saturating time accumulators
  localparam int DT_W        = 15;      // clamped elapsed time
  localparam int DT_CLAMP    = 16384;   // 0.25 s
  localparam int HL_MIN      = 655;
  localparam int DB_PER_LOG2 = 394566;  // 20*log10(2) in Q8.8 per Q16, scaled by 2^24

endpackage

`default_nettype wire

@@ rtl/pdag_if.sv @@
// Valid/ready channel interfaces: measurement in, gain out, register writes.
// Depends on pdag_pkg for payload widths.
`default_nettype none

interface pdag_in_if import pdag_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PEAK_W-1:0] output_peak;
  logic [TIME_W-1:0] elapsed;

  modport source (output valid, output output_peak, output elapsed, input ready);
  modport sink   (input valid, input output_peak, input elapsed, output ready);
endinterface

interface pdag_out_if import pdag_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GAIN_W-1:0] gain_db;

  modport source (output valid, output gain_db, input ready);
  modport sink   (input valid, input gain_db, output ready);
endinterface

interface pdag_cfg_if import pdag_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/peak_driven_auto_gain.sv @@
// Peak-driven automatic gain control: duck on loud peaks, slow climb after quiet.
// Depends on pdag_pkg and the channel interfaces in pdag_if.sv.
//
//   channel  dir  payload                       transfer when
//   meas     in   output_peak[17:0] elapsed[15:0]  meas.valid & meas.ready
//   gain     out  gain_db[15:0] signed          gain.valid & gain.ready
//   cfg      in   index[3:0] data[17:0]         cfg.valid & cfg.ready (always ready)
//
// Per item: zero elapsed or silence finishes at once; a duck over the ceiling runs
// two log2 evaluations and then the duck step; a climb runs one reciprocal divide,
// the decay steps and two log2 evaluations; a peak over the ceiling that sets no
// lower goal runs its log2 pair and then the climb. The shared 31x31 multiplier has
// a registered product, so each multiply state is followed by one that uses it.
// Reset (sync, active high) loads register defaults and the start state.
// meas is ready only while idle; a result waiting in the output register does not
// block the next measurement, but a second finished result holds meas off until
// the first one transfers.
`default_nettype none

module peak_driven_auto_gain import pdag_pkg::*; #(
  parameter int PEAK_HALF_LIFE    = DEF_PEAK_HALF_LIFE,
  parameter int DUCK_MARGIN       = DEF_DUCK_MARGIN,
  parameter int MEMORY_RESET_TIME = DEF_MEMORY_RESET_TIME,
  parameter int CLIMB_DELAY       = DEF_CLIMB_DELAY
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pdag_cfg_if.sink   cfg,
  pdag_in_if.sink    meas,
  pdag_out_if.source gain
);

  localparam int QW   = 31;   // quotient of (dt << 16) / half life
  localparam int MW   = 31;   // multiplier operand width
  localparam int LW   = 21;   // log2 result, Q16
  // Half life reciprocal: HLV < 2^HL_L, RECIP = ceil(2^(30+HL_L) / HLV) <= 2^31,
  // exact floor quotient for every clamped elapsed time
  localparam longint HLV  = (PEAK_HALF_LIFE < HL_MIN) ? HL_MIN : PEAK_HALF_LIFE;
  localparam int     HL_L = $clog2(HLV + 1);
  localparam logic [31:0] RECIP_V =
    32'(((64'd1 << (30 + HL_L)) + 64'(HLV) - 64'd1) / 64'(HLV));
  localparam int     RSH  = 14 + HL_L;
  localparam logic [TACC_W-1:0] MRT_V = TACC_W'(MEMORY_RESET_TIME);
  localparam logic [TACC_W-1:0] CLD_V = TACC_W'(CLIMB_DELAY);
  localparam logic signed [19:0] MARGIN_V = 20'(DUCK_MARGIN);
  localparam logic [MW-1:0] ONE_Q30 = MW'(1 << 30);

  typedef logic [15:0][MW-1:0] dfact_t;

  // Factors 2^-(2^(k-16)) in Q30, built by repeated floor square roots of 0.5
  function automatic dfact_t decay_factors();
    dfact_t      t;
    logic [63:0] c;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    int          k;
    int          i;
    t = '0;
    c = 64'd1 << 29;
    for (k = 15; k >= 0; k--) begin
      n = c << 30;
      r = '0;
      b = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      c = r;
      t[k] = MW'(c);
    end
    return t;
  endfunction

  localparam dfact_t DCF = decay_factors();

  // Position of the leading one
  function automatic logic [4:0] msb_pos(input logic [PEAK_W-1:0] v);
    logic [4:0] p;
    int         i;
    p = '0;
    for (i = 0; i < PEAK_W; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // Raise to lo, then lower to hi
  function automatic logic signed [GAIN_W-1:0] clamp_gain(
    input logic signed [19:0]       v,
    input logic signed [GAIN_W-1:0] lo,
    input logic signed [GAIN_W-1:0] hi
  );
    logic signed [19:0] t;
    t = v;
    if (t < 20'(lo)) t = 20'(lo);
    if (t > 20'(hi)) t = 20'(hi);
    return GAIN_W'(t);
  endfunction

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_LOG_INIT  = 16'h0002,
    S_LOG_MUL   = 16'h0004,
    S_LOG_ACC   = 16'h0008,
    S_DB_MUL    = 16'h0010,
    S_DB_FIN    = 16'h0020,
    S_DUCK_CHK  = 16'h0040,
    S_DUCK_MUL  = 16'h0080,
    S_DUCK_FIN  = 16'h0100,
    S_DIV       = 16'h0200,
    S_DEC_MUL   = 16'h0400,
    S_DEC_ACC   = 16'h0800,
    S_PM_MUL    = 16'h1000,
    S_PM_FIN    = 16'h2000,
    S_CLIMB_CHK = 16'h4000,
    S_CLIMB_FIN = 16'h8000
  } state_t;

  // Registers
  state_t st;
  logic   climb;       // current log/dB pass belongs to the climb path
  logic   first;       // first of the two log2 evaluations
  logic   busy_done;   // result ready for the output register
  logic   out_valid;
  logic signed [GAIN_W-1:0] out_gain;

  logic signed [GAIN_W-1:0] min_gain, max_gain;
  logic [PEAK_W-1:0]        silence_floor, ceiling_peak, climb_target;
  logic [TIME_W-1:0]        duck_rate, climb_rate;

  logic signed [GAIN_W-1:0] gain_now, duck_goal, allowed;
  logic [PEAK_W-1:0]        peak_memory;
  logic [TACC_W-1:0]        time_since_duck, silence_time;

  logic [PEAK_W-1:0] pk, log_src;
  logic [DT_W-1:0]   dtc;
  logic [4:0]        cnt, log_e;
  logic [MW-1:0]     m, r;
  logic [15:0]       frac;
  logic [LW-1:0]     log_t;
  logic              dneg;
  logic [LW-1:0]     dmag;
  logic [QW-1:0]     quo;
  logic [61:0]       prod;

  // Combinational helpers
  logic              cfg_fire, in_fire, out_free;
  logic [DT_W-1:0]   dt_in;
  logic [TACC_W:0]   sil_sum, tsd_sum;
  logic [TACC_W-1:0] sil_sat, tsd_sat;
  logic [MW-1:0]     mul_a, mul_b;
  logic [31:0]       sq;
  logic [15:0]       frac_next;
  logic [LW-1:0]     log_res;
  logic signed [LW:0] diff;
  logic [16:0]       db_mag;
  logic signed [19:0] db_v;
  logic signed [GAIN_W-1:0] db_gain;
  logic [31:0]       step_sum;
  logic signed [17:0] g_dn, g_up;
  logic [46:0]       div_prod;
  logic [PEAK_W-1:0] pm_v, pm_dec, pm_new;
  logic [14:0]       dec_n;

  assign cfg_fire = cfg.valid & cfg.ready;
  assign in_fire  = meas.valid & meas.ready;
  assign out_free = !out_valid || gain.ready;
  assign cfg.ready  = 1'b1;
  assign meas.ready = (st == S_IDLE) && !busy_done;
  assign gain.valid   = out_valid;
  assign gain.gain_db = out_gain;

  // Elapsed clamp and saturating time sums
  assign dt_in   = (meas.elapsed > TIME_W'(DT_CLAMP)) ? DT_W'(DT_CLAMP)
                                                     : DT_W'(meas.elapsed);
  assign sil_sum = {1'b0, silence_time} + (TACC_W+1)'(dt_in);
  assign sil_sat = sil_sum[TACC_W] ? '1 : sil_sum[TACC_W-1:0];
  assign tsd_sum = {1'b0, time_since_duck} + (TACC_W+1)'(dtc);
  assign tsd_sat = tsd_sum[TACC_W] ? '1 : tsd_sum[TACC_W-1:0];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      S_LOG_MUL: begin
        mul_a = m;
        mul_b = m;
      end
      S_DB_MUL: begin
        mul_a = MW'(dmag);
        mul_b = MW'(DB_PER_LOG2);
      end
      S_DUCK_MUL: begin
        mul_a = MW'(duck_rate);
        mul_b = MW'(dtc);
      end
      S_DEC_MUL: begin
        mul_a = r;
        mul_b = quo[cnt[3:0]] ? DCF[cnt[3:0]] : ONE_Q30;
      end
      S_PM_MUL: begin
        mul_a = MW'(peak_memory);
        mul_b = r;
      end
      S_CLIMB_CHK: begin
        mul_a = MW'(climb_rate);
        mul_b = MW'(dtc);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // log2 squaring step
  always_comb begin
    sq        = prod[61:30];
    frac_next = frac;
    frac_next[cnt[3:0]] = sq[31];
    log_res   = {log_e, frac_next};
    diff      = $signed({1'b0, log_t}) - $signed({1'b0, log_res});
  end

  // dB conversion and clamp
  always_comb begin
    db_mag  = 17'((prod[40:0] + 41'(1 << 23)) >> 24);
    db_v    = dneg ? -$signed({3'b0, db_mag}) : $signed({3'b0, db_mag});
    db_gain = clamp_gain(20'(gain_now) + db_v - (climb ? 20'sd0 : MARGIN_V),
                         min_gain, max_gain);
  end

  // Ramp steps
  assign step_sum = 32'(prod[30:0]) + 32'd32768;
  assign g_dn = 18'(gain_now) - $signed({2'b0, step_sum[31:16]});
  assign g_up = 18'(gain_now) + $signed({2'b0, step_sum[31:16]});

  // Elapsed time over half life by reciprocal multiplication
  assign div_prod = {32'b0, dtc} * {15'b0, RECIP_V};

  // Peak memory decay finish
  always_comb begin
    pm_v   = prod[47:30];
    dec_n  = quo[QW-1:16];
    pm_dec = (dec_n >= 15'(PEAK_W)) ? '0 : (pm_v >> dec_n[4:0]);
    pm_new = (pk > pm_dec) ? pk : pm_dec;
  end

  // Product register
  always_ff @(posedge clk) begin
    prod <= 62'(mul_a * mul_b);
  end

  // Sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= S_IDLE;
      climb           <= 1'b0;
      first           <= 1'b0;
      busy_done       <= 1'b0;
      out_valid       <= 1'b0;
      min_gain        <= RST_MIN_GAIN;
      max_gain        <= RST_MAX_GAIN;
      silence_floor   <= RST_SILENCE;
      ceiling_peak    <= RST_CEILING;
      climb_target    <= RST_CLIMB_TARGET;
      duck_rate       <= RST_DUCK_RATE;
      climb_rate      <= RST_CLIMB_RATE;
      gain_now        <= clamp_gain(20'(RST_START_GAIN), RST_MIN_GAIN, RST_MAX_GAIN);
      peak_memory     <= '0;
      duck_goal       <= RST_MAX_GAIN;
      time_since_duck <= '0;
      silence_time    <= '0;
      cnt             <= '0;
    end else begin
      // output register
      if (busy_done && out_free) begin
        out_valid <= 1'b1;
        out_gain  <= gain_now;
        busy_done <= 1'b0;
      end else if (out_valid && gain.ready) begin
        out_valid <= 1'b0;
      end

      case (st)
        S_IDLE: begin
          if (in_fire) begin
            pk  <= meas.output_peak;
            dtc <= dt_in;
            if (meas.elapsed == '0) begin
              busy_done <= 1'b1;
            end else if (meas.output_peak < silence_floor) begin
              silence_time <= sil_sat;
              if (sil_sat >= MRT_V) peak_memory <= '0;
              busy_done <= 1'b1;
            end else begin
              silence_time <= '0;
              climb        <= 1'b0;
              if (meas.output_peak > ceiling_peak) begin
                peak_memory <= meas.output_peak;
                if (ceiling_peak == '0) begin
                  if (clamp_gain(20'(min_gain), min_gain, max_gain) < duck_goal)
                    duck_goal <= clamp_gain(20'(min_gain), min_gain, max_gain);
                  st <= S_DUCK_CHK;
                end else begin
                  log_src <= ceiling_peak;
                  first   <= 1'b1;
                  st      <= S_LOG_INIT;
                end
              end else begin
                st <= S_DUCK_CHK;
              end
            end
          end
        end
        S_LOG_INIT: begin
          log_e <= msb_pos(log_src);
          m     <= MW'(log_src) << (5'd30 - msb_pos(log_src));
          frac  <= '0;
          cnt   <= 5'd15;
          st    <= S_LOG_MUL;
        end
        S_LOG_MUL: begin
          st <= S_LOG_ACC;
        end
        S_LOG_ACC: begin
          m    <= sq[31] ? sq[31:1] : sq[30:0];
          frac <= frac_next;
          if (cnt == '0) begin
            if (first) begin
              log_t   <= log_res;
              first   <= 1'b0;
              log_src <= climb ? peak_memory : pk;
              st      <= S_LOG_INIT;
            end else begin
              dneg <= diff[LW];
              dmag <= diff[LW] ? LW'(-diff) : LW'(diff);
              st   <= S_DB_MUL;
            end
          end else begin
            cnt <= cnt - 5'd1;
            st  <= S_LOG_MUL;
          end
        end
        S_DB_MUL: begin
          st <= S_DB_FIN;
        end
        S_DB_FIN: begin
          if (climb) begin
            allowed <= db_gain;
            st      <= S_CLIMB_CHK;
          end else begin
            if (db_gain < duck_goal) duck_goal <= db_gain;
            st <= S_DUCK_CHK;
          end
        end
        S_DUCK_CHK: begin
          if (gain_now > duck_goal) begin
            st <= S_DUCK_MUL;
          end else begin
            st <= S_DIV;
          end
        end
        S_DUCK_MUL: begin
          st <= S_DUCK_FIN;
        end
        S_DUCK_FIN: begin
          // clamp at the goal; reaching it releases the goal
          if (g_dn <= 18'(duck_goal)) begin
            gain_now  <= duck_goal;
            duck_goal <= max_gain;
          end else begin
            gain_now <= GAIN_W'(g_dn);
          end
          time_since_duck <= '0;
          busy_done       <= 1'b1;
          st              <= S_IDLE;
        end
        S_DIV: begin
          quo <= QW'(div_prod >> RSH);
          r   <= ONE_Q30;
          cnt <= 5'd15;
          st  <= S_DEC_MUL;
        end
        S_DEC_MUL: begin
          st <= S_DEC_ACC;
        end
        S_DEC_ACC: begin
          r <= prod[60:30];
          if (cnt == '0) begin
            st <= S_PM_MUL;
          end else begin
            cnt <= cnt - 5'd1;
            st  <= S_DEC_MUL;
          end
        end
        S_PM_MUL: begin
          st <= S_PM_FIN;
        end
        S_PM_FIN: begin
          peak_memory     <= pm_new;
          time_since_duck <= tsd_sat;
          climb           <= 1'b1;
          if (tsd_sat < CLD_V) begin
            busy_done <= 1'b1;
            st        <= S_IDLE;
          end else if (climb_target == '0) begin
            allowed <= clamp_gain(20'(min_gain), min_gain, max_gain);
            st      <= S_CLIMB_CHK;
          end else if (pm_new == '0) begin
            allowed <= clamp_gain(20'(max_gain), min_gain, max_gain);
            st      <= S_CLIMB_CHK;
          end else begin
            log_src <= climb_target;
            first   <= 1'b1;
            st      <= S_LOG_INIT;
          end
        end
        S_CLIMB_CHK: begin
          // multiplier runs the climb step here
          if (allowed > gain_now) begin
            st <= S_CLIMB_FIN;
          end else begin
            busy_done <= 1'b1;
            st        <= S_IDLE;
          end
        end
        S_CLIMB_FIN: begin
          gain_now  <= (g_up > 18'(allowed)) ? allowed : GAIN_W'(g_up);
          busy_done <= 1'b1;
          st        <= S_IDLE;
        end
        default: begin
          st <= S_IDLE;
        end
      endcase

      // register writes; start gain also reloads the state
      if (cfg_fire) begin
        case (cfg.index)
          REG_MIN_GAIN:     min_gain      <= cfg.data[GAIN_W-1:0];
          REG_MAX_GAIN:     max_gain      <= cfg.data[GAIN_W-1:0];
          REG_START_GAIN: begin
            gain_now        <= clamp_gain(20'($signed(cfg.data[GAIN_W-1:0])),
                                          min_gain, max_gain);
            peak_memory     <= '0;
            duck_goal       <= max_gain;
            time_since_duck <= '0;
            silence_time    <= '0;
          end
          REG_SILENCE:      silence_floor <= cfg.data;
          REG_CEILING:      ceiling_peak  <= cfg.data;
          REG_CLIMB_TARGET: climb_target  <= cfg.data;
          REG_DUCK_RATE:    duck_rate     <= cfg.data[TIME_W-1:0];
          REG_CLIMB_RATE:   climb_rate    <= cfg.data[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // A result loaded into the output register carries the gain of that moment
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (busy_done && out_free) |=> (out_valid && out_gain == $past(gain_now)))
    else $error("output register not loaded with current gain");

  // Measurements are taken only while the sequencer is idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE) |-> !meas.ready)
    else $error("measurement accepted while busy");

  // A duck step never lands below the goal it was aiming at
  a_duck_floor: assert property (@(posedge clk) disable iff (rst)
    (st == S_DUCK_FIN && !cfg_fire) |=> (gain_now >= $past(duck_goal)))
    else $error("duck step overshot its goal");

  // A climb step never lowers the gain
  a_climb_up: assert property (@(posedge clk) disable iff (rst)
    (st == S_CLIMB_FIN && !cfg_fire) |=> (gain_now >= $past(gain_now)))
    else $error("climb step lowered the gain");

endmodule

`default_nettype wire
